[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the minimum-tracking queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define MTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules clocked by i_clk and reset by i_rst_n.
`define MTF_ASSERT_CLK(lbl, prop, msg) \
    `MTF_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

[src/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// mtf_pkg
// Types, codes and constants shared by the minimum-tracking queue.
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int VALUE_W         = 32;
    localparam int CNT_W_DEF       = $clog2(QUEUE_DEPTH_DEF + 1);

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // latch the incoming request
        logic enq_write;    // write the value store, advance the write side
        logic rd_front_min; // read front and candidate head
        logic deq;          // remove the front entry
        logic trim_rd;      // read the newest candidate
        logic trim_pop;     // drop the newest candidate
        logic cand_write;   // append the new value as a candidate
        logic clear;        // empty the queue
        logic set_empty;    // flag a dequeue on an empty queue
        logic set_full;     // flag a dropped enqueue
        logic load_result;  // move the result into the output register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic cand_nonempty;
        logic cand_last;
        logic trim_gt;
        logic out_free;
    } t_dp_stat;

endpackage

[src/mtf_cmd_if.sv]
// ----------------------------------------------------------------------------
// mtf_cmd_if
// Request channel of the minimum-tracking queue: command and value.
// ----------------------------------------------------------------------------
interface mtf_cmd_if;
    import mtf_pkg::*;

    logic                      valid;
    logic                      ready;
    t_cmd                      cmd;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

[src/mtf_res_if.sv]
// ----------------------------------------------------------------------------
// mtf_res_if
// Result channel of the minimum-tracking queue.
// ----------------------------------------------------------------------------
interface mtf_res_if #(
    parameter int CNT_W = mtf_pkg::CNT_W_DEF
);
    import mtf_pkg::*;

    logic                      valid;
    logic                      ready;
    t_status                   status;
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] min_value;
    logic                      holds_items;
    logic [CNT_W-1:0]          item_count;

    modport source (output valid, output status, output popped_value, output front_value,
                    output min_value, output holds_items, output item_count, input ready);
    modport sink   (input valid, input status, input popped_value, input front_value,
                    input min_value, input holds_items, input item_count, output ready);
endinterface

[src/mtf_ctrl.sv]
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer of the minimum-tracking queue: steps each request through
// decode, dequeue or candidate trimming, memory reads and result hand-off.
// ----------------------------------------------------------------------------
module mtf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mtf_pkg::t_dp_stat  i_stat,
    output mtf_pkg::t_ctl_cmd  o_cmd
);
    import mtf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_DEQ      = 8'b0000_0100,
        S_TRIM_RD  = 8'b0000_1000,
        S_TRIM_CMP = 8'b0001_0000,
        S_CAND_WR  = 8'b0010_0000,
        S_FETCH    = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                // Front and head are read here so that a dequeue finds them next cycle.
                o_cmd.rd_front_min = 1'b1;
                case (i_stat.cmd)
                    CMD_ENQ: begin
                        if (i_stat.full) begin
                            o_cmd.set_full = 1'b1;
                            n_state        = S_FETCH;
                        end else begin
                            o_cmd.enq_write = 1'b1;
                            n_state = i_stat.cand_nonempty ? S_TRIM_RD : S_CAND_WR;
                        end
                    end
                    CMD_DEQ: begin
                        if (i_stat.empty) begin
                            o_cmd.set_empty = 1'b1;
                            n_state         = S_FETCH;
                        end else begin
                            n_state = S_DEQ;
                        end
                    end
                    CMD_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FETCH;
                    end
                    default: begin
                        n_state = S_FETCH;
                    end
                endcase
            end
            S_DEQ: begin
                o_cmd.deq = 1'b1;
                n_state   = S_FETCH;
            end
            S_TRIM_RD: begin
                o_cmd.trim_rd = 1'b1;
                n_state       = S_TRIM_CMP;
            end
            S_TRIM_CMP: begin
                // Candidates strictly greater than the new value can never be the minimum.
                if (i_stat.trim_gt) begin
                    o_cmd.trim_pop = 1'b1;
                    n_state = i_stat.cand_last ? S_CAND_WR : S_TRIM_RD;
                end else begin
                    n_state = S_CAND_WR;
                end
            end
            S_CAND_WR: begin
                o_cmd.cand_write = 1'b1;
                n_state          = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.rd_front_min = 1'b1;
                n_state            = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/mtf_dpath.sv]
// ----------------------------------------------------------------------------
// mtf_dpath
// Datapath of the minimum-tracking queue: value ring, candidate ring,
// pointers, counts and the output register.
// ----------------------------------------------------------------------------
module mtf_dpath #(
    parameter int QUEUE_DEPTH = mtf_pkg::QUEUE_DEPTH_DEF,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mtf_pkg::t_cmd                      i_cmd,
    input  logic signed [mtf_pkg::VALUE_W-1:0] i_value,
    input  mtf_pkg::t_ctl_cmd                  i_ctl,
    output mtf_pkg::t_dp_stat                  o_stat,
    mtf_res_if.source                          o_res_ch
);
    import mtf_pkg::*;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    logic signed [VALUE_W-1:0] r_val_mem  [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] r_cand_mem [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] r_val_rd;
    logic signed [VALUE_W-1:0] r_cand_rd;

    logic [PTR_W-1:0] r_rp, r_wp, r_head, r_tail;
    logic [CNT_W-1:0] r_count, r_ccnt;

    t_cmd                      r_cmd;
    logic signed [VALUE_W-1:0] r_value;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_popped;

    logic                      r_out_valid;
    t_status                   r_o_status;
    logic signed [VALUE_W-1:0] r_o_popped;
    logic signed [VALUE_W-1:0] r_o_front;
    logic signed [VALUE_W-1:0] r_o_min;
    logic                      r_o_holds;
    logic [CNT_W-1:0]          r_o_count;

    logic [PTR_W-1:0] cand_raddr;
    logic             deq_head_hit;

    assign cand_raddr   = i_ctl.trim_rd ? ptr_prev(r_tail) : r_head;
    assign deq_head_hit = (r_ccnt != '0) && (r_cand_rd == r_val_rd);

    assign o_stat.cmd           = r_cmd;
    assign o_stat.full          = (r_count == FULL_CNT);
    assign o_stat.empty         = (r_count == '0);
    assign o_stat.cand_nonempty = (r_ccnt != '0);
    assign o_stat.cand_last     = (r_ccnt == CNT_W'(1));
    assign o_stat.trim_gt       = (r_cand_rd > r_value);
    assign o_stat.out_free      = !r_out_valid || o_res_ch.ready;

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (i_ctl.enq_write) begin
            r_val_mem[r_wp] <= r_value;
        end
        if (i_ctl.rd_front_min) begin
            r_val_rd <= r_val_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cand_write) begin
            r_cand_mem[r_tail] <= r_value;
        end
        if (i_ctl.rd_front_min || i_ctl.trim_rd) begin
            r_cand_rd <= r_cand_mem[cand_raddr];
        end
    end

    // Request and status registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd    <= i_cmd;
            r_value  <= i_value;
            r_status <= ST_OK;
            r_popped <= '0;
        end else if (i_ctl.set_empty) begin
            r_status <= ST_EMPTY;
        end else if (i_ctl.set_full) begin
            r_status <= ST_FULL;
        end else if (i_ctl.deq) begin
            r_popped <= r_val_rd;
        end
    end

    // Pointers and counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_ccnt  <= '0;
        end else if (i_ctl.enq_write) begin
            r_wp    <= ptr_next(r_wp);
            r_count <= r_count + 1'b1;
        end else if (i_ctl.deq) begin
            r_rp    <= ptr_next(r_rp);
            r_count <= r_count - 1'b1;
            // The head candidate leaves only when it is the value being removed.
            if (deq_head_hit) begin
                r_head <= ptr_next(r_head);
                r_ccnt <= r_ccnt - 1'b1;
            end
        end else if (i_ctl.trim_pop) begin
            r_tail <= ptr_prev(r_tail);
            r_ccnt <= r_ccnt - 1'b1;
        end else if (i_ctl.cand_write) begin
            r_tail <= ptr_next(r_tail);
            r_ccnt <= r_ccnt + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_result) begin
            r_o_status <= r_status;
            r_o_popped <= r_popped;
            r_o_front  <= (r_count != '0) ? r_val_rd : '0;
            r_o_min    <= ((r_count != '0) && (r_ccnt != '0)) ? r_cand_rd : '0;
            r_o_holds  <= (r_count != '0);
            r_o_count  <= r_count;
        end
    end

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.status       = r_o_status;
    assign o_res_ch.popped_value = r_o_popped;
    assign o_res_ch.front_value  = r_o_front;
    assign o_res_ch.min_value    = r_o_min;
    assign o_res_ch.holds_items  = r_o_holds;
    assign o_res_ch.item_count   = r_o_count;

endmodule

[src/min_tracking_fifo.sv]
// ----------------------------------------------------------------------------
// min_tracking_fifo
// FIFO of signed 32-bit values that reports its front and minimum after
// every request.
// ----------------------------------------------------------------------------
// Each request (enqueue, dequeue, clear or query) gives exactly one result.
// Values sit in a ring of QUEUE_DEPTH entries; a second ring holds, oldest
// first, the values that no later value undercuts, so its head is the
// minimum. Each ring is a memory with one write port and one registered read
// port, and that read port sets the timing. Each request passes decode, then
// a dequeue step or candidate trimming and write where needed, then a fetch
// of front and minimum and the result hand-off. An enqueue takes longer for
// every candidate it compares against, because each comparison needs its own
// memory read. An enqueue compares against the candidates it removes plus at
// most one that it keeps, and each value is removed at most once. The output
// register lets a new request in while a result still waits to be taken. An
// enqueue into a full queue is dropped and flagged; a dequeue on an empty
// queue is flagged.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_tracking_fifo #(
    parameter int QUEUE_DEPTH = mtf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtf_cmd_if.sink   i_cmd_ch,
    mtf_res_if.source o_res_ch
);
    import mtf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_ctl_cmd ctl_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    assign i_cmd_ch.ready = in_ready;

    mtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_ch.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (ctl_cmd)
    );

    mtf_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd_ch.cmd),
        .i_value  (i_cmd_ch.value),
        .i_ctl    (ctl_cmd),
        .o_stat   (dp_stat),
        .o_res_ch (o_res_ch)
    );

    logic trim_pop;
    logic cand_held;
    logic res_valid;
    logic res_full;
    logic res_at_cap;
    logic res_empty;
    logic res_cleared;
    logic res_holds_ok;

    assign trim_pop     = ctl_cmd.trim_pop;
    assign cand_held    = dp_stat.cand_nonempty;
    assign res_valid    = o_res_ch.valid;
    assign res_full     = o_res_ch.valid && (o_res_ch.status == ST_FULL);
    assign res_at_cap   = (o_res_ch.item_count == CNT_W'(QUEUE_DEPTH));
    assign res_empty    = o_res_ch.valid && (o_res_ch.status == ST_EMPTY);
    assign res_cleared  = (o_res_ch.item_count == '0) && (o_res_ch.popped_value == '0) &&
                          !o_res_ch.holds_items;
    assign res_holds_ok = (o_res_ch.holds_items == (o_res_ch.item_count != '0));

    // A candidate is only ever dropped while at least one is held.
    `MTF_ASSERT_CLK(a_trim_has_cand, trim_pop |-> cand_held, "trim on empty candidate ring")

    // A dropped enqueue is only reported with the queue full.
    `MTF_ASSERT_CLK(a_full_count, res_full |-> res_at_cap, "full status with queue not full")

    // An empty dequeue removes nothing and leaves an empty queue.
    `MTF_ASSERT(a_empty_result, i_clk, i_rst_n, res_empty |-> res_cleared, "bad empty result")

    // The valid flag of front and minimum follows the count.
    `MTF_ASSERT_CLK(a_holds_count, res_valid |-> res_holds_ok, "holds flag disagrees")

endmodule
